// ----- sv/b38cp_pkg.sv -----
// Package for the base-38 callsign packer: transaction structs, state and status codes,
// and the character-to-digit mapping.
// No dependencies.
package b38cp_pkg;

	// Field and accumulator geometry.
	localparam int unsigned MAX_FIELD_CHARS = 24;
	localparam int unsigned LEN_W           = 5;
	localparam int unsigned LIMB_W          = 32;
	localparam int unsigned ACC_W           = 128;
	localparam int unsigned CARRY_W         = 6;
	localparam logic [LEN_W-1:0] FIELD_LENGTH_RESET = 5'd13;
	localparam logic [LEN_W-1:0] COUNT_MAX          = 5'd31;
	localparam logic [LEN_W-1:0] MAX_LEN            = LEN_W'(MAX_FIELD_CHARS);

	// Base-38 digit codes.
	localparam logic [CARRY_W-1:0] DIGIT_SPACE  = 6'd0;
	localparam logic [CARRY_W-1:0] DIGIT_LETTER = 6'd1;
	localparam logic [CARRY_W-1:0] DIGIT_SLASH  = 6'd27;
	localparam logic [CARRY_W-1:0] DIGIT_NUMBER = 6'd28;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_CHAR   = 2'd1,
		ST_OVERLENGTH = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CHECK,
		S_PAD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic [61:0] value_high;
		logic [63:0] value_low;
		status_t     status;
	} result_t;

	typedef struct packed {
		logic               ok;
		logic [CARRY_W-1:0] value;
	} digit_t;

	// Maps one character byte to its base-38 digit; ok is low for characters with no digit.
	function automatic digit_t char_digit(input logic [7:0] c);
		digit_t d;
		d.ok    = 1'b1;
		d.value = DIGIT_SPACE;
		if (c == 8'd32) begin
			d.value = DIGIT_SPACE;
		end else if (c >= 8'd65 && c <= 8'd90) begin
			d.value = CARRY_W'(c - 8'd65) + DIGIT_LETTER;
		end else if (c >= 8'd97 && c <= 8'd122) begin
			d.value = CARRY_W'(c - 8'd97) + DIGIT_LETTER;
		end else if (c == 8'd47) begin
			d.value = DIGIT_SLASH;
		end else if (c >= 8'd48 && c <= 8'd57) begin
			d.value = CARRY_W'(c - 8'd48) + DIGIT_NUMBER;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

// ----- sv/base38_callsign_packer.sv -----
// Top level of the base-38 callsign packer: sequencer, shared limb multiplier and result register.
// Depends on b38cp_pkg.
//
// The block takes a callsign one character per transaction and returns one result transaction
// (packed value and status) after the character flagged last. All arithmetic runs through one
// 32-bit by 38 multiply-add unit that walks the 128-bit accumulator one limb per cycle, so each
// multiply by 38 takes four limb steps. A character that adds a digit occupies the block for its
// accept step plus four limb steps; an ignored character is only accepted. After the last
// character come a check state and, for a clean string, a pad step plus four limb steps for each
// padding space (field_length clamped to MAX_LEN, minus characters received) and a pad step that
// ends the padding; then the emit state loads the result register. A result waiting to be taken
// holds the block only when the next callsign finishes before it is taken.
module base38_callsign_packer
	import b38cp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  logic             char_valid,
	output logic             char_stall,
	input  char_item_t       char_item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	state_t               state_q, state_d;
	logic [LEN_W-1:0]     field_length_q;
	logic [ACC_W-1:0]     acc_q;
	logic [CARRY_W-1:0]   carry_q;
	logic [1:0]           limb_q;
	logic [LEN_W-1:0]     count_q;
	logic [LEN_W-1:0]     pad_q;
	logic                 bad_q;
	logic                 ovl_q;
	logic                 last_q;
	logic                 pad_mode_q;
	status_t              status_q;
	logic                 result_valid_q;
	result_t              result_q;

	logic [LEN_W-1:0]     len_eff;
	digit_t               dig;
	logic [LEN_W-1:0]     count_new;
	logic                 ovl_new;
	logic                 bad_new;
	logic                 char_fire;
	logic                 emit_fire;
	status_t              status_chk;
	logic [LIMB_W+CARRY_W-1:0] prod;
	logic [LIMB_W-1:0]    limb_new;

	// Effective length, clamped to the widest field.
	assign len_eff = (field_length_q > MAX_LEN) ? MAX_LEN : field_length_q;

	// Per-character flags as they stand after this character.
	assign dig       = char_digit(char_item.char_code);
	assign count_new = (count_q < COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign ovl_new   = ovl_q | (count_new > len_eff);
	assign bad_new   = bad_q | ~dig.ok;

	// Final status, with the count tested again against the current length.
	always_comb begin
		if (ovl_q || (count_q > len_eff)) begin
			status_chk = ST_OVERLENGTH;
		end else if (bad_q) begin
			status_chk = ST_BAD_CHAR;
		end else begin
			status_chk = ST_OK;
		end
	end

	// Shared unit: lowest limb times 38 plus carry; the top two accumulator bits are kept clear.
	assign prod = {{CARRY_W{1'b0}}, acc_q[LIMB_W-1:0]} * (LIMB_W+CARRY_W)'(38)
		+ {{LIMB_W{1'b0}}, carry_q};
	always_comb begin
		limb_new = prod[LIMB_W-1:0];
		if (limb_q == 2'd3) begin
			limb_new[LIMB_W-1 -: 2] = 2'b00;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (char_valid) begin
					if (!ovl_new && dig.ok) begin
						state_d = S_MUL;
					end else if (char_item.last) begin
						state_d = S_CHECK;
					end
				end
			end
			S_MUL: begin
				if (limb_q == 2'd3) begin
					if (pad_mode_q) begin
						state_d = S_PAD;
					end else if (last_q) begin
						state_d = S_CHECK;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_CHECK: begin
				state_d = (status_chk == ST_OK) ? S_PAD : S_EMIT;
			end
			S_PAD: begin
				state_d = (pad_q == '0) ? S_EMIT : S_MUL;
			end
			S_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake outputs and strobes.
	always_comb begin
		char_stall = (state_q != S_IDLE);
		char_fire  = (state_q == S_IDLE) && char_valid;
		emit_fire  = (state_q == S_EMIT) && (!result_valid_q || !result_stall);
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			field_length_q <= FIELD_LENGTH_RESET;
			result_valid_q <= 1'b0;
			count_q        <= '0;
			bad_q          <= 1'b0;
			ovl_q          <= 1'b0;
			acc_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				field_length_q <= cfg_wr_data;
			end
			if (emit_fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (char_fire) begin
				count_q <= count_new;
				bad_q   <= bad_new;
				ovl_q   <= ovl_new;
			end else if (state_q == S_CHECK) begin
				ovl_q <= (status_chk == ST_OVERLENGTH);
			end else if (emit_fire) begin
				count_q <= '0;
				bad_q   <= 1'b0;
				ovl_q   <= 1'b0;
			end
			// Accumulator rotates one limb per multiply step.
			if (state_q == S_MUL) begin
				acc_q <= {limb_new, acc_q[ACC_W-1:LIMB_W]};
			end else if (emit_fire) begin
				acc_q <= '0;
			end
		end
	end

	// Sequencer working registers and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				carry_q    <= dig.value;
				limb_q     <= 2'd0;
				last_q     <= char_item.last;
				pad_mode_q <= 1'b0;
			end
			S_MUL: begin
				carry_q <= prod[LIMB_W+CARRY_W-1:LIMB_W];
				limb_q  <= limb_q + 2'd1;
			end
			S_CHECK: begin
				status_q <= status_chk;
				pad_q    <= len_eff - count_q;
			end
			S_PAD: begin
				carry_q    <= DIGIT_SPACE;
				limb_q     <= 2'd0;
				pad_mode_q <= 1'b1;
				pad_q      <= pad_q - 1'b1;
			end
			S_EMIT: begin
				if (emit_fire) begin
					result_q.status <= status_q;
					if (status_q == ST_OK) begin
						result_q.value_high <= acc_q[125:64];
						result_q.value_low  <= acc_q[63:0];
					end else begin
						result_q.value_high <= '0;
						result_q.value_low  <= '0;
					end
				end
			end
			default: begin
				limb_q <= 2'd0;
			end
		endcase
	end

	// The multiply carry never reaches 38, so no limb product overflows.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (carry_q < 6'd38))
		else $error("multiply carry out of range");

	// The accumulator stays within 126 bits whenever a limb walk is not in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_MUL) |-> (acc_q[ACC_W-1 -: 2] == 2'b00))
		else $error("accumulator exceeded 126 bits");

	// An error result carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (result_q.status != ST_OK)) |->
		((result_q.value_high == '0) && (result_q.value_low == '0)))
		else $error("error result with non-zero value");

	// Padding only starts once the string has been checked clean.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && state_d == S_PAD) |-> (count_q <= len_eff))
		else $error("padding started on an overlength string");

endmodule

// ----- verif/base38_callsign_packer_test.sv -----
// Self-checking testbench for the base-38 callsign packer: a predictor of the packed value and
// status, directed and random callsigns, random idling on both channels and a long output hold.
// Depends on b38cp_pkg and base38_callsign_packer.
module base38_callsign_packer_test;
	import b38cp_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 200;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_ITEMS  = 800;
	localparam int PHASE_ITEMS   = 90;
	localparam int REPORT_LIMIT  = 10;
	localparam longint WATCHDOG  = 64'd12_000_000;

	typedef enum int {
		CS_CLEAN,
		CS_BAD_CHAR,
		CS_TOO_LONG,
		CS_NOISE
	} callsign_kind_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_wr_en    = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data  = '0;
	logic             char_valid   = 1'b0;
	logic             char_stall;
	char_item_t       char_item    = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;

	// Predictor state: the callsign being packed and the field length in force.
	logic [LEN_W-1:0] field_len_model = FIELD_LENGTH_RESET;
	logic [125:0]     pack_acc        = '0;
	logic [LEN_W-1:0] pack_count      = '0;
	logic             pack_bad        = 1'b0;
	logic             pack_over       = 1'b0;
	result_t          awaited_packs[$];

	int fault_count = 0;
	int chars_sent  = 0;

	// Idling controls, each written by one process only.
	bit tx_quiet      = 1'b0;
	bit rx_quiet      = 1'b0;
	int hold_requests = 0;
	int hold_served   = 0;
	int rx_left       = 0;
	bit rx_holding    = 1'b0;

	base38_callsign_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_item    (char_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog for a hung run.
	initial begin
		#WATCHDOG;
		$display("base38_callsign_packer test failed");
		$finish;
	end

	// Reports a failure; only the first few are printed.
	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endtask

	// Base-38 digit of one byte, or -1 where the byte has none.
	function automatic int base38_digit(input logic [7:0] c);
		if (c == " ") return int'(DIGIT_SPACE);
		if (c >= "A" && c <= "Z") return int'(c - "A") + int'(DIGIT_LETTER);
		if (c >= "a" && c <= "z") return int'(c - "a") + int'(DIGIT_LETTER);
		if (c == "/") return int'(DIGIT_SLASH);
		if (c >= "0" && c <= "9") return int'(c - "0") + int'(DIGIT_NUMBER);
		return -1;
	endfunction

	// Folds one accepted character into the predicted callsign and queues the result on the last.
	task automatic pack_char(input char_item_t it);
		logic [LEN_W-1:0] eff;
		int               d;
		result_t          r;
		eff = (field_len_model > MAX_LEN) ? MAX_LEN : field_len_model;
		if (pack_count != COUNT_MAX) pack_count++;
		if (pack_count > eff) pack_over = 1'b1;
		d = base38_digit(it.char_code);
		if (d < 0) pack_bad = 1'b1;
		if (!pack_over && d >= 0) pack_acc = pack_acc * 126'd38 + 126'(d);
		if (it.last) begin
			r = '0;
			if (pack_over) begin
				r.status = ST_OVERLENGTH;
			end else if (pack_bad) begin
				r.status = ST_BAD_CHAR;
			end else begin
				r.status = ST_OK;
				for (int k = int'(pack_count); k < int'(eff); k++) pack_acc = pack_acc * 126'd38;
				r.value_high = pack_acc[125:64];
				r.value_low  = pack_acc[63:0];
			end
			awaited_packs.push_back(r);
			pack_acc   = '0;
			pack_count = '0;
			pack_bad   = 1'b0;
			pack_over  = 1'b0;
		end
	endtask

	// Sender gap: mostly none, some short, a few long.
	function automatic int next_tx_gap();
		int r;
		if (tx_quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one character transaction and waits until it is accepted.
	task automatic offer_char(input logic [7:0] code, input logic last);
		char_item_t it;
		int         gap;
		it.char_code = code;
		it.last      = last;
		gap = next_tx_gap();
		repeat (gap) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= it;
		do @(posedge clk); while (char_stall);
		chars_sent++;
		pack_char(it);
	endtask

	task automatic offer_text(input string s, input logic ends);
		for (int i = 0; i < s.len(); i++) begin
			offer_char(s[i], ends && (i == s.len() - 1));
		end
	endtask

	// Waits for every awaited result, then lets the block finish any work in progress.
	task automatic settle_idle(input int extra);
		char_valid <= 1'b0;
		while (awaited_packs.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Writes the field length register; only called while the block is idle.
	task automatic set_field_length(input logic [LEN_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		field_len_model = v;
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] callsign_char();
		case ($urandom_range(0, 4))
			0:       return " ";
			1:       return 8'("A" + $urandom_range(0, 25));
			2:       return 8'("a" + $urandom_range(0, 25));
			3:       return "/";
			default: return 8'("0" + $urandom_range(0, 9));
		endcase
	endfunction

	// Builds and sends one random callsign, mostly well formed.
	task automatic send_random_callsign();
		logic [7:0]     text[$];
		callsign_kind_t kind;
		int             eff;
		int             n;
		int             pick;
		eff  = (field_len_model > MAX_LEN) ? int'(MAX_LEN) : int'(field_len_model);
		pick = $urandom_range(0, 99);
		kind = (pick < 75) ? CS_CLEAN : (pick < 85) ? CS_BAD_CHAR :
			(pick < 95) ? CS_TOO_LONG : CS_NOISE;
		case (kind)
			CS_TOO_LONG: n = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 34) :
				$urandom_range(eff + 1, eff + 4);
			CS_NOISE:    n = $urandom_range(1, 6);
			default:     n = $urandom_range(1, (eff == 0) ? 2 : eff);
		endcase
		for (int i = 0; i < n; i++) begin
			text.push_back((kind == CS_NOISE) ? 8'($urandom_range(0, 255)) : callsign_char());
		end
		if (kind == CS_BAD_CHAR) text[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
		for (int i = 0; i < n; i++) begin
			offer_char(text[i], i == n - 1);
		end
	endtask

	// Receiver stalls: random runs, quiet stretches and an occasional long hold on request.
	always @(posedge clk) begin
		int r;
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			rx_holding  = 1'b1;
			rx_left     = LONG_HOLD;
		end else if (rx_left == 0) begin
			r = $urandom_range(0, 99);
			if (rx_quiet || r < 65) begin
				rx_holding = 1'b0;
				rx_left    = rx_quiet ? 1 : $urandom_range(1, 8);
			end else if (r < 95) begin
				rx_holding = 1'b1;
				rx_left    = $urandom_range(1, 3);
			end else begin
				rx_holding = 1'b1;
				rx_left    = $urandom_range(20, 60);
			end
		end
		result_stall <= rx_holding;
		rx_left = rx_left - 1;
	end

	// Compares each accepted result transaction with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_packs.size() == 0) begin
				note_fault($sformatf("unexpected result: high=%h low=%h status=%0d",
					result.value_high, result.value_low, result.status));
			end else begin
				want = awaited_packs.pop_front();
				if (result.value_high !== want.value_high || result.value_low !== want.value_low ||
						result.status !== want.status) begin
					note_fault($sformatf(
						"mismatch: expected high=%h low=%h status=%0d, got high=%h low=%h status=%0d",
						want.value_high, want.value_low, want.status,
						result.value_high, result.value_low, result.status));
				end
			end
		end
	end

	// Every digit class at its edges, then the bytes just outside each class.
	task automatic test_char_classes();
		logic [7:0] outside[10] = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2E, 8'h3A, 8'h1F, 8'h21,
			8'hFF, 8'h00};
		offer_text("AZaz /09", 1'b1);
		for (int i = 0; i < 10; i++) begin
			offer_char(outside[i], i == 9);
		end
		settle_idle(SETTLE_CYCLES);
	endtask

	// Shortest and zero lengths, lengths above the maximum, and overlength over a bad character.
	task automatic test_length_limits();
		set_field_length(5'd1);
		offer_text("K", 1'b1);
		offer_text("KA", 1'b1);
		offer_text("@A", 1'b1);
		settle_idle(SETTLE_CYCLES);
		set_field_length(5'd0);
		offer_text("A", 1'b1);
		settle_idle(SETTLE_CYCLES);
		set_field_length(5'd31);
		offer_text("Q", 1'b1);
		settle_idle(SETTLE_CYCLES);
		set_field_length(MAX_LEN);
		offer_text("/", 1'b1);
		settle_idle(SETTLE_CYCLES);
	endtask

	// The length is changed part way through a callsign, both down and up.
	task automatic test_midstring_length_change();
		set_field_length(5'd5);
		offer_text("AB", 1'b0);
		settle_idle(SETTLE_CYCLES);
		set_field_length(5'd1);
		offer_text("C", 1'b1);
		settle_idle(SETTLE_CYCLES);
		set_field_length(5'd2);
		offer_text("AB", 1'b0);
		settle_idle(SETTLE_CYCLES);
		set_field_length(5'd5);
		offer_text("C", 1'b1);
		settle_idle(SETTLE_CYCLES);
	endtask

	// The receiver holds off for a long stretch while short callsigns keep arriving.
	task automatic test_result_backpressure();
		set_field_length(5'd4);
		hold_requests++;
		@(posedge clk);
		tx_quiet = 1'b1;
		repeat (12) send_random_callsign();
		tx_quiet = 1'b0;
		settle_idle(SETTLE_CYCLES);
	endtask

	// Random callsigns in phases, each with its own field length and idling mix.
	task automatic test_random_callsigns();
		int first_lengths[5] = '{24, 1, 0, 31, 13};
		int phase;
		int start;
		int done;
		phase = 0;
		done  = 0;
		while (done < RANDOM_ITEMS) begin
			if (phase < 5) begin
				set_field_length(LEN_W'(first_lengths[phase]));
			end else begin
				set_field_length(LEN_W'($urandom_range(0, 31)));
			end
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			start = chars_sent;
			while (chars_sent - start < PHASE_ITEMS) send_random_callsign();
			done += chars_sent - start;
			settle_idle(SETTLE_CYCLES);
			phase++;
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Reset once, run every test, then drain and give the verdict.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_char_classes();
		test_length_limits();
		test_midstring_length_change();
		test_result_backpressure();
		test_random_callsigns();
		settle_idle(TAIL_CYCLES);
		if (awaited_packs.size() != 0) begin
			note_fault($sformatf("%0d results never arrived", awaited_packs.size()));
		end
		if (fault_count == 0) begin
			$display("base38_callsign_packer test passed");
		end else begin
			$display("base38_callsign_packer test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/b38cp_pkg.sv
sv/base38_callsign_packer.sv
verif/base38_callsign_packer_test.sv
